[rtl/msq_pkg.sv]
package msq_pkg;

	localparam int NOTE_W = 7;
	localparam int VEL_W = 7;
	localparam int GATE_W = 9;
	localparam int LEN_W = 24;
	localparam int GC_W = 25;
	localparam int SC_W = 26;
	localparam int LFSR_W = 16;
	localparam int NSTEP_W = 6;
	localparam int CFG_IDX_W = 3;

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
	localparam logic [7:0] NOTE_CENTER = 8'd60;
	localparam logic [VEL_W-1:0] DEF_VEL = 7'd100;
	localparam logic [GATE_W-1:0] DEF_GATE = 9'd128;
	localparam logic [GATE_W-1:0] GATE_MIN = 9'd13;
	localparam logic [GATE_W-1:0] GATE_MAX = 9'd256;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	localparam logic [LEN_W-1:0] STEP_LENGTH_RST = 24'd12000;
	localparam logic [NSTEP_W-1:0] NUM_STEPS_RST = 6'd16;
	localparam logic [7:0] SWING_RST = 8'd0;

	localparam logic [NOTE_W-1:0] SCALE [16] = '{
		7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd69, 7'd71, 7'd72,
		7'd72, 7'd71, 7'd69, 7'd67, 7'd65, 7'd64, 7'd62, 7'd60
	};

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_STOP    = 2'd2,
		CMD_WRITE   = 2'd3
	} cmd_kind_t;

	typedef enum logic [1:0] {
		DIR_FWD  = 2'd0,
		DIR_BWD  = 2'd1,
		DIR_PING = 2'd2,
		DIR_RAND = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_LENGTH = 3'd0,
		REG_NUM_STEPS   = 3'd1,
		REG_DIRECTION   = 3'd2,
		REG_SWING       = 3'd3
	} cfg_reg_t;

	typedef enum logic {
		EV_OFF = 1'b0,
		EV_ON  = 1'b1
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ON,
		ST_SWING,
		ST_ADV
	} st_t;

	typedef struct packed {
		logic              active;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic [GATE_W-1:0] gate;
	} ent_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [NOTE_W-1:0] tnote;
		logic [4:0]        idx;
		ent_t              ent;
	} cmd_t;

	typedef struct packed {
		ev_kind_t          kind;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic [4:0]        step;
		logic              last;
	} evt_t;

	typedef struct packed {
		logic [LEN_W-1:0]   step_length;
		logic [NSTEP_W-1:0] num_steps;
		dir_t               dir;
		logic [7:0]         swing;
	} cfg_t;

	function automatic logic [NOTE_W-1:0] scale_note(input logic [3:0] idx);
		return SCALE[idx];
	endfunction

endpackage

[rtl/msq_fifo.sv]
module msq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic [$clog2(DEPTH):0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = AW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [LW-1:0] cnt_q;
	logic do_wr, do_rd, empty;

	assign full = (cnt_q == LW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign level = cnt_q;
	assign rd_data = mem_q[rp_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/msq_ram.sv]
module msq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/msq_divmod.sv]
module msq_divmod import msq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LFSR_W-1:0] dividend,
	input  logic [NSTEP_W-1:0] divisor,
	output logic              busy,
	output logic [NSTEP_W-1:0] rem
);

	localparam int CW = $clog2(LFSR_W + 1);

	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [LFSR_W-1:0] dvd_q;
	logic [NSTEP_W-1:0] dsr_q, rem_q;
	logic [NSTEP_W:0] trial;
	logic [NSTEP_W-1:0] rem_next;

	assign busy = busy_q;
	assign rem = rem_q;
	assign trial = {rem_q, dvd_q[LFSR_W-1]};

	always_comb begin
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = NSTEP_W'(trial - {1'b0, dsr_q});
		end else begin
			rem_next = NSTEP_W'(trial);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LFSR_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(LFSR_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/msq_front.sv]
module msq_front import msq_pkg::*; #(
	parameter int PATTERN_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic [NOTE_W-1:0] trigger_note,
	input  logic [4:0]        entry_index,
	input  logic              entry_active,
	input  logic [NOTE_W-1:0] entry_note,
	input  logic [VEL_W-1:0]  entry_velocity,
	input  logic [GATE_W-1:0] entry_gate,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output cmd_t              cmd
);

	cmd_t item;
	logic drop;
	logic [$clog2(CMD_DEPTH):0] q_level;
	logic [$bits(cmd_t)-1:0] q_data;

	always_comb begin
		item.kind = cmd_kind_t'(command);
		item.tnote = trigger_note;
		item.idx = entry_index;
		item.ent.active = entry_active;
		item.ent.note = entry_note;
		item.ent.vel = (entry_velocity == '0) ? VEL_W'(1) : entry_velocity;
		if (entry_gate < GATE_MIN) begin
			item.ent.gate = GATE_MIN;
		end else if (entry_gate > GATE_MAX) begin
			item.ent.gate = GATE_MAX;
		end else begin
			item.ent.gate = entry_gate;
		end
		drop = (item.kind == CMD_WRITE) && (9'(entry_index) >= 9'(PATTERN_DEPTH));
	end

	msq_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push && !drop),
		.wr_data(item),
		.full(full),
		.rd_en(cmd_pop),
		.rd_data(q_data),
		.level(q_level)
	);

	assign cmd_valid = (q_level != '0);
	assign cmd = cmd_t'(q_data);

endmodule

[rtl/msq_back.sv]
module msq_back import msq_pkg::*; #(
	parameter int PATTERN_DEPTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	input  logic res_room,
	output logic evt_wr,
	output evt_t evt
);

	localparam int PW = $clog2(PATTERN_DEPTH);

	st_t state_q, state_d;

	logic [PW-1:0] position_q, played_q;
	logic up_q, even_q, run_q, snd_q, pend_q;
	logic [NOTE_W-1:0] snd_note_q;
	logic [GC_W-1:0] gc_q;
	logic [SC_W-1:0] sc_q;
	logic signed [7:0] tr_q;
	logic [LFSR_W-1:0] lfsr_q, lfsr_next;
	logic ent_act_q;
	logic [NOTE_W-1:0] ent_note_q;
	logic [VEL_W-1:0] ent_vel_q;
	logic [PATTERN_DEPTH-1:0] valid_q;
	logic vld_s1;
	logic [32:0] mul_s1;

	logic [LEN_W-1:0] len;
	logic [NSTEP_W-1:0] ns, n_steps;
	logic expire, gate_off;
	ent_t ram_rd, ram_wd;
	logic ram_we;
	logic [PW-1:0] ram_wa;
	logic act_now;
	logic [NOTE_W-1:0] pn_now, note_clamped;
	logic [VEL_W-1:0] vel_now;
	logic [GATE_W-1:0] gate_now, mul_b;
	logic signed [9:0] note_sum;
	logic [8:0] p9, n9;
	logic [PW-1:0] pp_pos;
	logic pp_up;
	logic div_start, div_busy;
	logic [LFSR_W-1:0] div_dvd;
	logic [NSTEP_W-1:0] div_rem;
	logic [GC_W-1:0] gate_len;
	logic [SC_W-1:0] reload;

	assign len = (cfg.step_length == '0) ? LEN_W'(1) : cfg.step_length;
	assign ns = (cfg.num_steps == '0) ? NSTEP_W'(1) : cfg.num_steps;
	assign n_steps = (9'(ns) > 9'(PATTERN_DEPTH)) ? NSTEP_W'(PATTERN_DEPTH) : ns;
	assign expire = (sc_q[SC_W-1:1] == '0);
	assign gate_off = (gc_q == GC_W'(1)) && snd_q;
	assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	assign ram_we = cmd_pop && (cmd.kind == CMD_WRITE);
	assign ram_wa = PW'(cmd.idx);
	assign ram_wd = cmd.ent;

	msq_ram #(
		.WIDTH($bits(ent_t)),
		.DEPTH(PATTERN_DEPTH)
	) u_pattern (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(position_q),
		.rdata(ram_rd)
	);

	always_comb begin
		act_now = vld_s1 ? ram_rd.active : (9'(position_q) < 9'd16);
		pn_now = vld_s1 ? ram_rd.note : scale_note(position_q[3:0]);
		vel_now = vld_s1 ? ram_rd.vel : DEF_VEL;
		gate_now = vld_s1 ? ram_rd.gate : DEF_GATE;
		note_sum = $signed({3'b000, pn_now}) + $signed({{2{tr_q[7]}}, tr_q});
		if (note_sum < 0) begin
			note_clamped = '0;
		end else if (note_sum > $signed({3'b000, NOTE_MAX})) begin
			note_clamped = NOTE_MAX;
		end else begin
			note_clamped = note_sum[NOTE_W-1:0];
		end
	end

	always_comb begin
		p9 = 9'(position_q);
		n9 = 9'(n_steps);
		pp_up = up_q;
		pp_pos = position_q;
		if (up_q && (p9 + 9'd1 >= n9)) begin
			pp_up = 1'b0;
			pp_pos = (n9 >= 9'd2) ? PW'(n9 - 9'd2) : '0;
		end else if (up_q) begin
			pp_pos = PW'(p9 + 9'd1);
		end else if (p9 == '0) begin
			pp_up = 1'b1;
			pp_pos = (n9 == 9'd1) ? '0 : PW'(1);
		end else if (p9 - 9'd1 >= n9) begin
			pp_up = 1'b0;
			pp_pos = (n9 >= 9'd2) ? PW'(n9 - 9'd2) : '0;
		end else begin
			pp_pos = PW'(p9 - 9'd1);
		end
	end

	assign div_start = (state_q == ST_ON) && (cfg.dir != DIR_PING);

	always_comb begin
		unique case (cfg.dir)
			DIR_FWD:  div_dvd = LFSR_W'(position_q) + LFSR_W'(1);
			DIR_BWD:  div_dvd = LFSR_W'(position_q) + LFSR_W'(n_steps) - LFSR_W'(1);
			default:  div_dvd = lfsr_next;
		endcase
	end

	msq_divmod u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(n_steps),
		.busy(div_busy),
		.rem(div_rem)
	);

	assign mul_b = (state_q == ST_READ) ? gate_now : GATE_W'(cfg.swing);
	assign gate_len = (mul_s1[32:8] == '0) ? GC_W'(1) : mul_s1[32:8];
	assign reload = (cfg.swing != '0 && !even_q)
		? SC_W'(len) + SC_W'(mul_s1[31:8]) : SC_W'(len);

	always_ff @(posedge clk) begin
		mul_s1 <= 33'(len) * 33'(mul_b);
		vld_s1 <= valid_q[position_q];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop && cmd.kind == CMD_TICK && run_q && expire) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_ON;
			ST_ON: state_d = ST_SWING;
			ST_SWING: state_d = (cfg.dir == DIR_PING) ? ST_IDLE : ST_ADV;
			ST_ADV: state_d = div_busy ? ST_ADV : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		evt_wr = 1'b0;
		evt.kind = EV_OFF;
		evt.note = snd_note_q;
		evt.vel = '0;
		evt.step = 5'(played_q);
		evt.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && res_room) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						CMD_STOP: evt_wr = snd_q;
						CMD_TRIGGER: evt_wr = !run_q && snd_q;
						CMD_TICK: evt_wr = run_q && !expire && gate_off;
						default: evt_wr = 1'b0;
					endcase
				end
			end
			ST_READ: begin
				evt_wr = pend_q;
				evt.last = !act_now;
			end
			ST_ON: begin
				evt_wr = ent_act_q;
				evt.kind = EV_ON;
				evt.note = ent_note_q;
				evt.vel = ent_vel_q;
			end
			default: evt_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			position_q <= '0;
			played_q <= '0;
			up_q <= 1'b1;
			even_q <= 1'b1;
			run_q <= 1'b0;
			snd_q <= 1'b0;
			pend_q <= 1'b0;
			snd_note_q <= '0;
			gc_q <= '0;
			sc_q <= SC_W'(STEP_LENGTH_RST);
			tr_q <= '0;
			lfsr_q <= LFSR_SEED;
			ent_act_q <= 1'b0;
			ent_note_q <= '0;
			ent_vel_q <= '0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.kind)
							CMD_WRITE: valid_q[ram_wa] <= 1'b1;
							CMD_STOP: begin
								snd_q <= 1'b0;
								snd_note_q <= '0;
								gc_q <= '0;
								position_q <= '0;
								up_q <= 1'b1;
								even_q <= 1'b1;
								tr_q <= '0;
								sc_q <= SC_W'(len);
								run_q <= 1'b0;
							end
							CMD_TRIGGER: begin
								if (!run_q) begin
									snd_q <= 1'b0;
									gc_q <= '0;
									position_q <= '0;
									sc_q <= '0;
									even_q <= 1'b1;
									up_q <= 1'b1;
									run_q <= 1'b1;
								end
								tr_q <= $signed({1'b0, cmd.tnote}) - $signed(NOTE_CENTER);
							end
							default: begin
								if (run_q && expire) begin
									pend_q <= snd_q;
									snd_q <= 1'b0;
									gc_q <= '0;
								end else if (run_q) begin
									sc_q <= sc_q - 1'b1;
									if (gc_q != '0) begin
										gc_q <= gc_q - 1'b1;
									end
									if (gate_off) begin
										snd_q <= 1'b0;
									end
								end
							end
						endcase
					end
				end
				ST_READ: begin
					pend_q <= 1'b0;
					played_q <= position_q;
					ent_act_q <= act_now;
					ent_note_q <= note_clamped;
					ent_vel_q <= vel_now;
				end
				ST_ON: begin
					if (ent_act_q) begin
						snd_q <= 1'b1;
						snd_note_q <= ent_note_q;
						gc_q <= gate_len;
					end
					even_q <= !even_q;
					if (cfg.dir == DIR_PING) begin
						position_q <= pp_pos;
						up_q <= pp_up;
					end
					if (cfg.dir == DIR_RAND) begin
						lfsr_q <= lfsr_next;
					end
				end
				ST_SWING: sc_q <= reload;
				ST_ADV: begin
					if (!div_busy) begin
						position_q <= PW'(div_rem);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/midi_step_sequencer_top.sv]
// Step sequencer driven by one command request at a time.
// Input side is a queue: a request (command plus its fields) is taken on a
// clock edge with push high and full low. Results leave through a queue: the
// oldest note event sits on the result ports while empty is low and is taken
// on an edge with pop high. Each request yields zero, one or two events; the
// final one carries last_event.
// Configuration goes through cfg_valid/cfg_ready with cfg_index/cfg_data;
// cfg_ready is always high. Write it only while the sequencer is quiet.
// Timing: a request is decoded into a two-entry command queue, from which the
// sequencer core takes it. A tick that ends no step writes its event into the
// result queue as the core takes it. A tick that ends a step walks the core
// through its read, on and swing states and, except in ping-pong mode, an
// advance state that waits for the bit-serial remainder unit that finds the
// next step; the note-off is written in the read state and the note-on in the
// on state.
// Reset loads the default pattern and registers and stops playback. When the
// result queue has fewer than two free entries the core holds, the command
// queue fills and full rises; nothing is dropped.
module midi_step_sequencer_top import msq_pkg::*; #(
	parameter int PATTERN_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           command,
	input  logic [NOTE_W-1:0]    trigger_note,
	input  logic [4:0]           entry_index,
	input  logic                 entry_active,
	input  logic [NOTE_W-1:0]    entry_note,
	input  logic [VEL_W-1:0]     entry_velocity,
	input  logic [GATE_W-1:0]    entry_gate,
	output logic                 empty,
	input  logic                 pop,
	output logic                 event_kind,
	output logic [NOTE_W-1:0]    note_number,
	output logic [VEL_W-1:0]     note_velocity,
	output logic [4:0]           step_played,
	output logic                 last_event,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

	localparam int RLW = $clog2(RES_DEPTH) + 1;

	cfg_t cfg_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	logic evt_wr;
	evt_t evt, res;
	logic res_full;
	logic [RLW-1:0] res_level;
	logic res_room;
	logic [$bits(evt_t)-1:0] res_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_length <= STEP_LENGTH_RST;
			cfg_q.num_steps <= NUM_STEPS_RST;
			cfg_q.dir <= DIR_FWD;
			cfg_q.swing <= SWING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEP_LENGTH: cfg_q.step_length <= cfg_data;
				REG_NUM_STEPS: cfg_q.num_steps <= cfg_data[NSTEP_W-1:0];
				REG_DIRECTION: cfg_q.dir <= dir_t'(cfg_data[1:0]);
				REG_SWING: cfg_q.swing <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	msq_front #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.trigger_note(trigger_note),
		.entry_index(entry_index),
		.entry_active(entry_active),
		.entry_note(entry_note),
		.entry_velocity(entry_velocity),
		.entry_gate(entry_gate),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd)
	);

	msq_back #(
		.PATTERN_DEPTH(PATTERN_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop),
		.cmd(cmd),
		.res_room(res_room),
		.evt_wr(evt_wr),
		.evt(evt)
	);

	assign res_room = (res_level <= RLW'(RES_DEPTH - 2));

	msq_fifo #(
		.WIDTH($bits(evt_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(evt_wr),
		.wr_data(evt),
		.full(res_full),
		.rd_en(pop),
		.rd_data(res_data),
		.level(res_level)
	);

	assign empty = (res_level == '0);
	assign res = evt_t'(res_data);
	assign event_kind = res.kind;
	assign note_number = res.note;
	assign note_velocity = res.vel;
	assign step_played = res.step;
	assign last_event = res.last;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		evt_wr |-> !res_full)
		else $error("result queue written while full");

	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command taken from empty queue");

	a_note_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_wr && evt.kind == EV_ON) |-> evt.last)
		else $error("note-on not marked as final event");

	a_pop_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> res_level <= RLW'(RES_DEPTH - 2))
		else $error("command started without room for two events");

endmodule
